>>> rtl/hbp_pkg.sv
// Package for the HTTP header block parser: result kinds, error codes,
// parser phases, the result bundle passed from front to back, and
// character constants. No dependencies.
package hbp_pkg;

  localparam int LEN_BITS_DEF    = 16;
  localparam int COUNT_BITS_DEF  = 8;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int MAX_RES         = 3;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_HT    = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_NAME_TERM = 2'd1;
  localparam logic [1:0] ERR_SIZE      = 2'd2;
  localparam logic [1:0] ERR_COUNT     = 2'd3;

  localparam logic ADDR_SIZE_BUDGET = 1'b0;
  localparam logic ADDR_COUNT_LIMIT = 1'b1;

  typedef enum logic [2:0] {
    K_NAME     = 3'd0,
    K_NAME_END = 3'd1,
    K_VALUE    = 3'd2,
    K_HDR_END  = 3'd3,
    K_BLK_END  = 3'd4,
    K_ERROR    = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_LINE     = 3'd1,
    PH_NAME     = 3'd2,
    PH_LWS      = 3'd3,
    PH_VALUE    = 3'd4,
    PH_EOL_ONE  = 3'd5,
    PH_EOL_CRLF = 3'd6,
    PH_EOL_LFCR = 3'd7
  } phase_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic [1:0] err;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t [MAX_RES-1:0] res;
  } bundle_t;

  function automatic logic is_name_char(input logic [7:0] c);
    logic ok;
    ok = (c >= 8'd33) && (c <= 8'd126);
    case (c)
      8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C,
      8'h22, 8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D: ok = 1'b0;
      default: ;
    endcase
    return ok;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_HT);
  endfunction

endpackage

>>> rtl/hbp_front.sv
// Front end of the header block parser: accepts one byte beat per cycle
// while in_ready_i is high, runs the parsing state machine and forms a
// bundle of up to three results. Depends on hbp_pkg.
module hbp_front #(
  parameter int LEN_BITS   = 16,
  parameter int COUNT_BITS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic             mode_i,
  input  logic [7:0]       byte_i,
  input  logic [15:0]      size_budget_i,
  input  logic [7:0]       count_limit_i,
  output logic             push_o,
  output hbp_pkg::bundle_t bundle_o
);
  import hbp_pkg::*;

  localparam int CW = (LEN_BITS + 1 > 16) ? LEN_BITS + 1 : 16;
  localparam int HW = (COUNT_BITS > 8) ? COUNT_BITS : 8;

  phase_e                phase_q, phase_d;
  logic                  held_cr_q, held_cr_d;
  logic                  held_lf_q, held_lf_d;
  logic [LEN_BITS-1:0]   name_len_q, name_len_d;
  logic [LEN_BITS-1:0]   value_len_q, value_len_d;
  logic [15:0]           budget_q, budget_d;
  logic [COUNT_BITS-1:0] hdr_cnt_q, hdr_cnt_d;

  logic                  fire;
  logic [1:0]            n;
  bundle_t               b;
  logic                  do_ls;
  logic                  do_name;
  logic [LEN_BITS:0]     used;
  logic [LEN_BITS:0]     vsum;
  logic [1:0]            fold_cnt;

  assign fire = in_valid_i && in_ready_i;

  always_comb begin
    phase_d     = phase_q;
    held_cr_d   = held_cr_q;
    held_lf_d   = held_lf_q;
    name_len_d  = name_len_q;
    value_len_d = value_len_q;
    budget_d    = budget_q;
    hdr_cnt_d   = hdr_cnt_q;
    n           = 2'd0;
    b           = '0;
    do_ls       = 1'b0;
    do_name     = 1'b0;
    fold_cnt    = 2'd0;
    used        = {1'b0, name_len_q} + {1'b0, value_len_q};
    vsum        = '0;
    if (fire) begin
      if (mode_i) begin
        phase_d     = PH_LINE;
        held_cr_d   = 1'b0;
        held_lf_d   = 1'b0;
        name_len_d  = '0;
        value_len_d = '0;
        budget_d    = size_budget_i;
        hdr_cnt_d   = '0;
      end else begin
        unique case (phase_q)
          PH_IDLE: ;
          PH_LINE: do_ls = 1'b1;
          PH_NAME: do_name = 1'b1;
          PH_LWS, PH_VALUE, PH_EOL_ONE, PH_EOL_CRLF, PH_EOL_LFCR: begin
            if (phase_q == PH_LWS && is_blank(byte_i)) begin
              phase_d = PH_LWS;
            end else if (phase_q == PH_LWS || phase_q == PH_VALUE) begin
              if (byte_i == CH_CR) begin
                held_cr_d = 1'b1;
                phase_d   = PH_EOL_ONE;
              end else if (byte_i == CH_LF) begin
                held_lf_d = 1'b1;
                phase_d   = PH_EOL_ONE;
              end else begin
                b.res[n] = '{kind: K_VALUE, data: byte_i, err: ERR_NONE};
                n = n + 2'd1;
                if (value_len_q != '1) value_len_d = value_len_q + 1'b1;
                phase_d = PH_VALUE;
              end
            end else if (phase_q == PH_EOL_ONE && held_cr_q && !held_lf_q
                         && byte_i == CH_LF) begin
              held_lf_d = 1'b1;
              phase_d   = PH_EOL_CRLF;
            end else if (phase_q == PH_EOL_ONE && held_lf_q && !held_cr_q
                         && byte_i == CH_CR) begin
              held_cr_d = 1'b1;
              phase_d   = PH_EOL_LFCR;
            end else if (is_blank(byte_i)) begin
              if (phase_q == PH_EOL_LFCR) begin
                b.res[n] = '{kind: K_VALUE, data: CH_LF, err: ERR_NONE};
                n = n + 2'd1;
                b.res[n] = '{kind: K_VALUE, data: CH_CR, err: ERR_NONE};
                n = n + 2'd1;
              end else begin
                if (held_cr_q) begin
                  b.res[n] = '{kind: K_VALUE, data: CH_CR, err: ERR_NONE};
                  n = n + 2'd1;
                end
                if (held_lf_q) begin
                  b.res[n] = '{kind: K_VALUE, data: CH_LF, err: ERR_NONE};
                  n = n + 2'd1;
                end
              end
              b.res[n] = '{kind: K_VALUE, data: byte_i, err: ERR_NONE};
              fold_cnt = n + 2'd1;
              n = n + 2'd1;
              vsum = {1'b0, value_len_q} + (LEN_BITS+1)'(fold_cnt);
              value_len_d = vsum[LEN_BITS] ? '1 : vsum[LEN_BITS-1:0];
              held_cr_d = 1'b0;
              held_lf_d = 1'b0;
              phase_d   = PH_VALUE;
            end else begin
              held_cr_d = 1'b0;
              held_lf_d = 1'b0;
              if (size_budget_i != 16'd0 && CW'(used) > CW'(budget_q)) begin
                b.res[n] = '{kind: K_ERROR, data: 8'd0, err: ERR_SIZE};
                n = n + 2'd1;
                phase_d = PH_IDLE;
              end else begin
                b.res[n] = '{kind: K_HDR_END, data: 8'd0, err: ERR_NONE};
                n = n + 2'd1;
                budget_d = (CW'(used) >= CW'(budget_q)) ? 16'd0
                                                        : budget_q - 16'(used);
                if (hdr_cnt_q != '1) hdr_cnt_d = hdr_cnt_q + 1'b1;
                do_ls = 1'b1;
              end
            end
          end
          default: ;
        endcase

        if (do_ls) begin
          if (byte_i == CH_CR || byte_i == CH_LF) begin
            b.res[n] = '{kind: K_BLK_END, data: 8'd0, err: ERR_NONE};
            n = n + 2'd1;
            phase_d = PH_IDLE;
          end else if (count_limit_i != 8'd0 && HW'(hdr_cnt_d) >= HW'(count_limit_i)) begin
            b.res[n] = '{kind: K_ERROR, data: 8'd0, err: ERR_COUNT};
            n = n + 2'd1;
            phase_d   = PH_IDLE;
            held_cr_d = 1'b0;
            held_lf_d = 1'b0;
          end else begin
            name_len_d  = '0;
            value_len_d = '0;
            phase_d     = PH_NAME;
            do_name     = 1'b1;
          end
        end

        if (do_name) begin
          if (is_name_char(byte_i)) begin
            b.res[n] = '{kind: K_NAME, data: byte_i, err: ERR_NONE};
            n = n + 2'd1;
            if (name_len_d != '1) name_len_d = name_len_d + 1'b1;
          end else if (byte_i == CH_COLON) begin
            if (size_budget_i != 16'd0 && CW'(name_len_d) > CW'(budget_d)) begin
              b.res[n] = '{kind: K_ERROR, data: 8'd0, err: ERR_SIZE};
              n = n + 2'd1;
              phase_d   = PH_IDLE;
              held_cr_d = 1'b0;
              held_lf_d = 1'b0;
            end else begin
              b.res[n] = '{kind: K_NAME_END, data: 8'd0, err: ERR_NONE};
              n = n + 2'd1;
              phase_d = PH_LWS;
            end
          end else begin
            b.res[n] = '{kind: K_ERROR, data: 8'd0, err: ERR_NAME_TERM};
            n = n + 2'd1;
            phase_d   = PH_IDLE;
            held_cr_d = 1'b0;
            held_lf_d = 1'b0;
          end
        end
      end
    end
    b.cnt = n;
  end

  assign push_o   = fire && (n != 2'd0);
  assign bundle_o = b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      held_cr_q   <= 1'b0;
      held_lf_q   <= 1'b0;
      name_len_q  <= '0;
      value_len_q <= '0;
      budget_q    <= '0;
      hdr_cnt_q   <= '0;
    end else begin
      phase_q     <= phase_d;
      held_cr_q   <= held_cr_d;
      held_lf_q   <= held_lf_d;
      name_len_q  <= name_len_d;
      value_len_q <= value_len_d;
      budget_q    <= budget_d;
      hdr_cnt_q   <= hdr_cnt_d;
    end
  end

endmodule

>>> rtl/hbp_queue.sv
// Short queue of result bundles between the parser front and the output
// back end. Depends on hbp_pkg.
module hbp_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  hbp_pkg::bundle_t wdata_i,
  input  logic             pop_i,
  output hbp_pkg::bundle_t rdata_o,
  output logic             empty_o,
  output logic             full_o
);
  import hbp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  bundle_t        mem_q [DEPTH];
  logic [PW-1:0]  wr_q, wr_d;
  logic [PW-1:0]  rd_q, rd_d;
  logic [CNW-1:0] cnt_q, cnt_d;
  logic           do_push;
  logic           do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CNW'(DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    if (do_pop)  rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= wdata_i;
  end

endmodule

>>> rtl/hbp_back.sv
// Back end of the header block parser: takes bundles from the queue and
// sends their results out one beat at a time from an output register.
// Depends on hbp_pkg.
module hbp_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hbp_pkg::bundle_t head_i,
  input  logic             empty_i,
  output logic             pop_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output hbp_pkg::res_t    res_o,
  output logic             last_o
);
  import hbp_pkg::*;

  bundle_t    cur_q, cur_d;
  logic       vld_q, vld_d;
  logic [1:0] idx_q, idx_d;
  logic       at_end;

  assign at_end      = (idx_q == cur_q.cnt - 2'd1);
  assign pop_o       = (!vld_q || (out_ready_i && at_end)) && !empty_i;
  assign out_valid_o = vld_q;
  assign res_o       = cur_q.res[idx_q];
  assign last_o      = at_end;

  always_comb begin
    cur_d = cur_q;
    vld_d = vld_q;
    idx_d = idx_q;
    if (pop_o) begin
      cur_d = head_i;
      vld_d = 1'b1;
      idx_d = 2'd0;
    end else if (vld_q && out_ready_i) begin
      if (at_end) begin
        vld_d = 1'b0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= 2'd0;
    end else begin
      vld_q <= vld_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

endmodule

>>> rtl/http_header_block_parser_unit.sv
// Top level of the HTTP header block parser: configuration registers,
// parser front, bundle queue and output back end.
// Depends on hbp_pkg, hbp_front, hbp_queue and hbp_back.
// Results pass the bundle queue, then the back end's output register. Throughput: one
// input beat per cycle while the queue is not full, one result beat per cycle while
// m_axis_tready is high; multi-result beats are absorbed by the QUEUE_DEPTH-entry queue.
// Reset: asynchronous, active low; parser idle, registers and counters zero, queue empty.
module http_header_block_parser_unit #(
  parameter int LEN_BITS    = hbp_pkg::LEN_BITS_DEF,
  parameter int COUNT_BITS  = hbp_pkg::COUNT_BITS_DEF,
  parameter int QUEUE_DEPTH = hbp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  input  logic        s_axis_tuser,   // [0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [9:8] error_code, zero pad
  output logic [2:0]  m_axis_tuser,   // [2:0] kind
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hbp_pkg::*;

  logic [15:0] size_budget_q;
  logic [7:0]  count_limit_q;
  logic        cfg_wr;
  logic        push;
  logic        pop;
  logic        empty;
  logic        full;
  bundle_t     push_bundle;
  bundle_t     head;
  res_t        out_res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == ADDR_COUNT_LIMIT) ? {24'd0, count_limit_q}
                                                 : {16'd0, size_budget_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_budget_q <= '0;
      count_limit_q <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == ADDR_SIZE_BUDGET) size_budget_q <= pwdata[15:0];
      else count_limit_q <= pwdata[7:0];
    end
  end

  assign s_axis_tready = !full;

  hbp_front #(
    .LEN_BITS  (LEN_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .mode_i       (s_axis_tuser),
    .byte_i       (s_axis_tdata),
    .size_budget_i(size_budget_q),
    .count_limit_i(count_limit_q),
    .push_o       (push),
    .bundle_o     (push_bundle)
  );

  hbp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(push_bundle),
    .pop_i  (pop),
    .rdata_o(head),
    .empty_o(empty),
    .full_o (full)
  );

  hbp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .empty_i    (empty),
    .pop_o      (pop),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .res_o      (out_res),
    .last_o     (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, out_res.err, out_res.data};
  assign m_axis_tuser = out_res.kind;

endmodule

>>> rtl/hbp_checker.sv
// Port-level checker for the HTTP header block parser, bound to the top level.
// Depends on hbp_pkg and http_header_block_parser_unit.
module hbp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import hbp_pkg::*;

  // A stalled result beat holds its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
       && $stable(m_axis_tlast)))
    else $error("result beat changed while stalled");

  // An error always ends the results of its input beat.
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == K_ERROR) |-> m_axis_tlast)
    else $error("error beat without tlast");

  // A block end always ends the results of its input beat.
  a_blk_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == K_BLK_END) |-> m_axis_tlast)
    else $error("block end beat without tlast");

  // The error code is nonzero exactly on error beats.
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tuser == K_ERROR) == (m_axis_tdata[9:8] != ERR_NONE)))
    else $error("error code does not match kind");

endmodule

bind http_header_block_parser_unit hbp_checker u_hbp_checker (.*);

>>> bench/tb_http_header_block_parser_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for http_header_block_parser_unit: a directed table and random header
// blocks are streamed in; result beats are checked against an in-bench parser model, or for
// typed table rows against the row's result. Depends on hbp_pkg and the RTL of the parser unit.
module tb_http_header_block_parser_unit;
  import hbp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam logic [2:0] REG_SIZE_BUDGET = {ADDR_SIZE_BUDGET, 2'b00};
  localparam logic [2:0] REG_COUNT_LIMIT = {ADDR_COUNT_LIMIT, 2'b00};

  typedef struct packed {
    logic       mode;
    logic [7:0] data;
    logic       typed;
    logic       has_res;
    kind_e      kind;
    logic [1:0] err;
  } beat_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic [1:0] err;
    logic       last;
  } hdr_result_t;

  localparam beat_t DIRECTED_ROWS [25] = '{
    '{1'b0, 8'h41,    1'b1, 1'b0, K_NAME,  ERR_NONE},
    '{1'b1, 8'h00,    1'b1, 1'b0, K_NAME,  ERR_NONE},
    '{1'b0, 8'hFF,    1'b1, 1'b1, K_ERROR, ERR_NAME_TERM},
    '{1'b1, 8'hFF,    1'b1, 1'b0, K_NAME,  ERR_NONE},
    '{1'b0, 8'h7E,    1'b0, 1'b0, K_NAME,  ERR_NONE},
    '{1'b0, CH_COLON, 1'b0, 1'b0, K_NAME,  ERR_NONE},
    '{1'b0, CH_SP,    1'b0, 1'b0, K_NAME,  ERR_NONE},
    '{1'b0, CH_HT,    1'b0, 1'b0, K_NAME,  ERR_NONE},
    '{1'b0, 8'h00,    1'b0, 1'b0, K_NAME,  ERR_NONE},
    '{1'b0, 8'hFF,    1'b0, 1'b0, K_NAME,  ERR_NONE},
    '{1'b0, CH_CR,    1'b0, 1'b0, K_NAME,  ERR_NONE},
    '{1'b0, CH_LF,    1'b0, 1'b0, K_NAME,  ERR_NONE},
    '{1'b0, CH_SP,    1'b0, 1'b0, K_NAME,  ERR_NONE},
    '{1'b0, CH_LF,    1'b0, 1'b0, K_NAME,  ERR_NONE},
    '{1'b0, CH_CR,    1'b0, 1'b0, K_NAME,  ERR_NONE},
    '{1'b0, CH_HT,    1'b0, 1'b0, K_NAME,  ERR_NONE},
    '{1'b0, CH_CR,    1'b0, 1'b0, K_NAME,  ERR_NONE},
    '{1'b0, 8'h58,    1'b0, 1'b0, K_NAME,  ERR_NONE},
    '{1'b0, CH_COLON, 1'b0, 1'b0, K_NAME,  ERR_NONE},
    '{1'b0, CH_LF,    1'b0, 1'b0, K_NAME,  ERR_NONE},
    '{1'b0, CH_LF,    1'b0, 1'b0, K_NAME,  ERR_NONE},
    '{1'b1, 8'h00,    1'b1, 1'b0, K_NAME,  ERR_NONE},
    '{1'b0, CH_COLON, 1'b0, 1'b0, K_NAME,  ERR_NONE},
    '{1'b0, CH_CR,    1'b0, 1'b0, K_NAME,  ERR_NONE},
    '{1'b0, CH_CR,    1'b0, 1'b0, K_NAME,  ERR_NONE}
  };

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;    // [7:0] byte_in
  logic        s_axis_tuser = 1'b0;     // [0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [15:0] m_axis_tdata;            // [7:0] data_byte, [9:8] error_code, zero pad
  logic [2:0]  m_axis_tuser;            // [2:0] kind
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // Model of the parser.
  logic [15:0] cfg_budget = 16'd0;
  logic [7:0]  cfg_hdr_limit = 8'd0;
  phase_e      ph = PH_IDLE;
  logic        h_cr = 1'b0;
  logic        h_lf = 1'b0;
  logic [15:0] name_len = 16'd0;
  logic [15:0] value_len = 16'd0;
  logic [15:0] budget_left = 16'd0;
  logic [7:0]  hdr_count = 8'd0;

  hdr_result_t beat_results[$];
  hdr_result_t pending_results[$];
  beat_t       beats[$];
  beat_t       drv = '0;
  int          sent_beats = 0;
  int          failures = 0;
  int          cycle;
  int          stall_left = 0;
  bit          quiet = 1'b0;
  bit          calm = 1'b0;

  http_header_block_parser_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  function automatic bit is_tchar(logic [7:0] c);
    if (c < 8'd33 || c > 8'd126) begin
      return 1'b0;
    end
    case (c)
      "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]", "?", "=", "{", "}":
        return 1'b0;
      default: return 1'b1;
    endcase
  endfunction

  function automatic bit is_lws(logic [7:0] c);
    return c == CH_SP || c == CH_HT;
  endfunction

  function automatic logic [15:0] len_sat_add(logic [15:0] a, logic [1:0] n);
    logic [16:0] s;
    s = a + n;
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  function automatic void emit_result(kind_e k, logic [7:0] d, logic [1:0] e);
    hdr_result_t r;
    r.kind = k;
    r.data = d;
    r.err  = e;
    r.last = 1'b0;
    beat_results.push_back(r);
  endfunction

  function automatic void abort_block(logic [1:0] code);
    emit_result(K_ERROR, 8'h00, code);
    ph   = PH_IDLE;
    h_cr = 1'b0;
    h_lf = 1'b0;
  endfunction

  function automatic void pred_name_char(logic [7:0] c);
    if (is_tchar(c)) begin
      emit_result(K_NAME, c, ERR_NONE);
      name_len = len_sat_add(name_len, 2'd1);
    end else if (c == CH_COLON) begin
      if (cfg_budget != 16'd0 && name_len > budget_left) begin
        abort_block(ERR_SIZE);
      end else begin
        emit_result(K_NAME_END, 8'h00, ERR_NONE);
        ph = PH_LWS;
      end
    end else begin
      abort_block(ERR_NAME_TERM);
    end
  endfunction

  function automatic void pred_header_start(logic [7:0] c);
    if (c == CH_CR || c == CH_LF) begin
      emit_result(K_BLK_END, 8'h00, ERR_NONE);
      ph = PH_IDLE;
    end else if (cfg_hdr_limit != 8'd0 && hdr_count >= cfg_hdr_limit) begin
      abort_block(ERR_COUNT);
    end else begin
      name_len  = 16'd0;
      value_len = 16'd0;
      ph        = PH_NAME;
      pred_name_char(c);
    end
  endfunction

  function automatic void pred_value_char(logic [7:0] c);
    if (c == CH_CR) begin
      h_cr = 1'b1;
      ph   = PH_EOL_ONE;
    end else if (c == CH_LF) begin
      h_lf = 1'b1;
      ph   = PH_EOL_ONE;
    end else begin
      emit_result(K_VALUE, c, ERR_NONE);
      value_len = len_sat_add(value_len, 2'd1);
      ph        = PH_VALUE;
    end
  endfunction

  function automatic void pred_line_end(logic [7:0] c);
    logic [16:0] used;
    logic [1:0]  n;
    if (is_lws(c)) begin
      n = 2'd1;
      if (ph == PH_EOL_LFCR) begin
        emit_result(K_VALUE, CH_LF, ERR_NONE);
        emit_result(K_VALUE, CH_CR, ERR_NONE);
        n = 2'd3;
      end else begin
        if (h_cr) begin
          emit_result(K_VALUE, CH_CR, ERR_NONE);
          n = n + 2'd1;
        end
        if (h_lf) begin
          emit_result(K_VALUE, CH_LF, ERR_NONE);
          n = n + 2'd1;
        end
      end
      emit_result(K_VALUE, c, ERR_NONE);
      value_len = len_sat_add(value_len, n);
      h_cr = 1'b0;
      h_lf = 1'b0;
      ph   = PH_VALUE;
    end else begin
      used = name_len + value_len;
      h_cr = 1'b0;
      h_lf = 1'b0;
      if (cfg_budget != 16'd0 && used > {1'b0, budget_left}) begin
        abort_block(ERR_SIZE);
      end else begin
        emit_result(K_HDR_END, 8'h00, ERR_NONE);
        budget_left = (used >= {1'b0, budget_left}) ? 16'd0 : budget_left - used[15:0];
        if (hdr_count != 8'hFF) begin
          hdr_count = hdr_count + 8'd1;
        end
        pred_header_start(c);
      end
    end
  endfunction

  // Returns 1 unless the beat is a data byte that the idle parser drops.
  function automatic bit predict_beat(logic mode, logic [7:0] c);
    if (mode) begin
      ph          = PH_LINE;
      h_cr        = 1'b0;
      h_lf        = 1'b0;
      name_len    = 16'd0;
      value_len   = 16'd0;
      budget_left = cfg_budget;
      hdr_count   = 8'd0;
      return 1'b1;
    end
    case (ph)
      PH_IDLE: return 1'b0;
      PH_LINE: pred_header_start(c);
      PH_NAME: pred_name_char(c);
      PH_LWS: begin
        if (!is_lws(c)) begin
          pred_value_char(c);
        end
      end
      PH_VALUE: pred_value_char(c);
      PH_EOL_ONE: begin
        if (h_cr && !h_lf && c == CH_LF) begin
          h_lf = 1'b1;
          ph   = PH_EOL_CRLF;
        end else if (h_lf && !h_cr && c == CH_CR) begin
          h_cr = 1'b1;
          ph   = PH_EOL_LFCR;
        end else begin
          pred_line_end(c);
        end
      end
      default: pred_line_end(c);
    endcase
    return 1'b1;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    for (cycle = 0; cycle < CYCLE_LIMIT; cycle++) begin
      @(posedge clk_i);
    end
    $display("simulation failed");
    $finish;
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready = 1'b0;
      stall_left--;
    end else if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
      m_axis_tready = 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  always @(posedge clk_i) begin : scoreboard
    hdr_result_t got;
    hdr_result_t want;
    hdr_result_t r;
    if (rst_ni) begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          REG_SIZE_BUDGET: cfg_budget = pwdata[15:0];
          REG_COUNT_LIMIT: cfg_hdr_limit = pwdata[7:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        beat_results.delete();
        void'(predict_beat(drv.mode, drv.data));
        sent_beats++;
        if (drv.typed) begin
          if (drv.has_res) begin
            r.kind = drv.kind;
            r.data = 8'h00;
            r.err  = drv.err;
            r.last = 1'b1;
            pending_results.push_back(r);
          end
        end else begin
          for (int i = 0; i < beat_results.size(); i++) begin
            r = beat_results[i];
            r.last = (i == beat_results.size() - 1);
            pending_results.push_back(r);
          end
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = kind_e'(m_axis_tuser);
        got.data = m_axis_tdata[7:0];
        got.err  = m_axis_tdata[9:8];
        got.last = m_axis_tlast;
        if (pending_results.size() == 0) begin
          if (failures < 10) begin
            $display("unexpected result beat: kind %0d data %02h err %0d last %0b",
                     got.kind, got.data, got.err, got.last);
          end
          failures++;
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            if (failures < 10) begin
              $write("result mismatch: expected kind %0d data %02h err %0d last %0b,",
                     want.kind, want.data, want.err, want.last);
              $display(" got kind %0d data %02h err %0d last %0b",
                       got.kind, got.data, got.err, got.last);
            end
            failures++;
          end
        end
      end
    end
  end

  task automatic send_all;
    beat_t nxt;
    while (beats.size() != 0) begin
      nxt = beats.pop_front();
      if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
        s_axis_tvalid = 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk_i);
      end
      drv           = nxt;
      s_axis_tvalid = 1'b1;
      s_axis_tdata  = nxt.data;
      s_axis_tuser  = nxt.mode;
      do @(posedge clk_i); while (!s_axis_tready);
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b0;
  endtask

  task automatic put_beat(logic mode, logic [7:0] c);
    beat_t b;
    b = '0;
    b.mode = mode;
    b.data = c;
    beats.push_back(b);
  endtask

  // Data byte with an occasional random corruption.
  task automatic put_byte(logic [7:0] c);
    if ($urandom_range(0, 29) == 0) begin
      c = 8'($urandom_range(0, 255));
    end
    put_beat(1'b0, c);
  endtask

  function automatic logic [7:0] gen_token();
    logic [7:0] c;
    do c = 8'($urandom_range(33, 126)); while (!is_tchar(c));
    return c;
  endfunction

  function automatic logic [7:0] gen_blank();
    return $urandom_range(0, 1) ? CH_SP : CH_HT;
  endfunction

  function automatic logic [7:0] gen_value();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_CR || c == CH_LF);
    return c;
  endfunction

  // Line end forms: CR, LF, CR LF or LF CR.
  task automatic put_line_end(int form);
    case (form)
      0: put_byte(CH_CR);
      1: put_byte(CH_LF);
      2: begin
        put_byte(CH_CR);
        put_byte(CH_LF);
      end
      default: begin
        put_byte(CH_LF);
        put_byte(CH_CR);
      end
    endcase
  endtask

  task automatic gen_block;
    int nh;
    int form;
    if ($urandom_range(0, 24) == 0) begin
      put_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      return;
    end
    put_beat(1'b1, 8'($urandom_range(0, 255)));
    nh = $urandom_range(0, 4);
    form = $urandom_range(0, 3);
    repeat (nh) begin
      repeat ($urandom_range(0, 6)) put_byte(gen_token());
      put_byte(CH_COLON);
      repeat ($urandom_range(0, 2)) put_byte(gen_blank());
      repeat ($urandom_range(0, 8)) put_byte(gen_value());
      if ($urandom_range(0, 3) == 0) begin
        put_line_end($urandom_range(0, 3));
        put_byte(gen_blank());
        repeat ($urandom_range(0, 4)) put_byte(gen_value());
      end
      form = $urandom_range(0, 3);
      put_line_end(form);
    end
    // A lone CR or LF must be repeated, or it would pair up with the block end.
    if (nh != 0 && form < 2) begin
      put_byte(form == 0 ? CH_CR : CH_LF);
    end else begin
      put_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
    end
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] value);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = addr;
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic drain;
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic run_phase(logic [15:0] budget, logic [7:0] hdr_limit, int n);
    int target;
    drain();
    apb_write(REG_SIZE_BUDGET, {16'd0, budget});
    apb_write(REG_COUNT_LIMIT, {24'd0, hdr_limit});
    target = sent_beats + n;
    while (sent_beats < target) begin
      calm = ($urandom_range(0, 4) == 0);
      gen_block();
      while (beats.size() > target - sent_beats) begin
        void'(beats.pop_back());
      end
      send_all();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
      beats.push_back(DIRECTED_ROWS[i]);
    end
    send_all();

    run_phase(16'hFFFF, 8'hFF, 23);
    run_phase(16'd1, 8'd1, 23);
    run_phase(16'd20, 8'd3, 23);
    run_phase(16'd0, 8'd2, 23);
    run_phase(16'd40, 8'd0, 23);
    repeat (2) run_phase(16'($urandom_range(0, 60)), 8'($urandom_range(0, 5)), 23);
    quiet = 1'b1;
    calm  = 1'b0;
    run_phase(16'($urandom_range(1, 60)), 8'($urandom_range(0, 5)), 23);

    drain();
    repeat (8) @(posedge clk_i);
    failures += pending_results.size();
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/hbp_pkg.sv
rtl/hbp_front.sv
rtl/hbp_queue.sv
rtl/hbp_back.sv
rtl/http_header_block_parser_unit.sv
rtl/hbp_checker.sv
bench/tb_http_header_block_parser_unit.sv
